// ===== rtl/core/afc_pkg.sv =====
// Shared types and constants for the audio format converter.
package afc_pkg;

    // Configuration port geometry
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam int DATA_W    = 32;
    localparam int STEP_W    = 21;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_IN_STEREO  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OUT_STEREO = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_IN_16BIT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUT_16BIT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RATE_STEP  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MUTE       = 3'd5;

    localparam logic [STEP_W-1:0] RATE_STEP_RESET = 21'd65536;

    // Results per item, and the counter that holds that count
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = 5;

    // Sample constants: sign flips (32768, 128) and silence levels (128 for 8-bit, 0 for 16-bit)
    localparam logic [15:0] SIGN_FLIP  = 16'h8000;
    localparam logic [7:0]  BYTE_FLIP  = 8'h80;
    localparam logic [15:0] SILENCE_8  = 16'd128;
    localparam logic [15:0] SILENCE_16 = 16'd0;

    typedef struct packed {
        logic [15:0] in_a;
        logic [15:0] in_b;
        logic        last_frame;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_a;
        logic [15:0] out_b;
        logic        sample_valid;
        logic        end_of_buffer;
    } t_out_item;

    typedef struct packed {
        logic              in_stereo;
        logic              out_stereo;
        logic              in_16bit;
        logic              out_16bit;
        logic [STEP_W-1:0] rate_step;
        logic              mute_enable;
    } t_cfg;

    // Lane control from the sequencer
    typedef struct packed {
        logic load;       // capture the current frame
        logic load_prev;  // also take it as the previous frame
        logic commit;     // current frame becomes the previous frame
    } t_lane_ctrl;

    // Side band that travels with the lane products
    typedef struct packed {
        logic valid;
        logic sample;
        logic eob;
    } t_side;

endpackage

// ===== rtl/core/afc_stream_if.sv =====
// Valid/ready stream channel carrying one item payload.
interface afc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/afc_lane.sv =====
// One channel lane: depth conversion, frame hold and linear interpolation.
module afc_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  afc_pkg::t_cfg         i_cfg,
    input  afc_pkg::t_lane_ctrl   i_ctrl,
    input  logic                  i_en,
    input  logic signed [15:0]    i_sample,
    input  logic [FRAC_BITS-1:0]  i_frac,
    output logic [15:0]           o_value
);
    localparam int PRW = 17 + FRAC_BITS + 1;

    logic signed [15:0]     r_cur;
    logic signed [15:0]     r_prev;
    logic signed [15:0]     r_p;
    logic signed [PRW-1:0]  r_prod;
    logic signed [15:0]     w_conv;
    logic signed [16:0]     w_diff;
    logic signed [PRW-1:0]  w_prod;
    logic signed [PRW-1:0]  w_num;
    logic signed [PRW-1:0]  w_q;
    logic                   w_round;

    // Convert sample depth: 8->16 is s*256-32768, 16->8 is (s+32768)/256
    always_comb begin
        if (i_cfg.in_16bit == i_cfg.out_16bit) begin
            w_conv = i_sample;
        end else if (i_cfg.out_16bit) begin
            w_conv = $signed({i_sample[7:0], 8'h00} ^ afc_pkg::SIGN_FLIP);
        end else begin
            w_conv = $signed({8'h00, i_sample[15:8] ^ afc_pkg::BYTE_FLIP});
        end
    end

    // Hold current and previous frame
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cur <= w_conv;
        end
        if (i_ctrl.load && i_ctrl.load_prev) begin
            r_prev <= w_conv;
        end else if (i_ctrl.commit) begin
            r_prev <= r_cur;
        end
    end

    // Multiply the frame difference by the phase fraction
    assign w_diff = 17'(r_cur) - 17'(r_prev);
    assign w_prod = PRW'(w_diff) * PRW'($signed({1'b0, i_frac}));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= r_prev;
            r_prod <= w_prod;
        end
    end

    // Add the base and scale down, truncating toward zero
    assign w_num   = (PRW'(r_p) <<< FRAC_BITS) + r_prod;
    assign w_q     = w_num >>> FRAC_BITS;
    assign w_round = w_num[PRW-1] && (|w_num[FRAC_BITS-1:0]);
    assign o_value = w_q[15:0] + 16'(w_round);

endmodule

// ===== rtl/core/afc_merge.sv =====
// Merge stage: combines both lanes into one result item and holds it.
module afc_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  afc_pkg::t_cfg       i_cfg,
    input  afc_pkg::t_side      i_side,
    input  logic [15:0]         i_left,
    input  logic [15:0]         i_right,
    output logic                o_en,
    afc_stream_if.source        o_out
);
    logic                r_out_valid;
    afc_pkg::t_out_item  r_out;
    afc_pkg::t_out_item  w_fmt;
    logic [15:0]         w_silence;

    // Advance whenever the output register is free or being drained
    assign o_en = !r_out_valid || o_out.ready;

    // Apply mute, mono output and end marker formatting
    always_comb begin
        w_silence = i_cfg.out_16bit ? afc_pkg::SILENCE_16 : afc_pkg::SILENCE_8;
        w_fmt.out_a         = i_left;
        w_fmt.out_b         = i_right;
        w_fmt.sample_valid  = i_side.sample;
        w_fmt.end_of_buffer = i_side.eob;
        if (i_side.sample && i_cfg.mute_enable) begin
            w_fmt.out_a = w_silence;
            w_fmt.out_b = w_silence;
        end
        if (!i_side.sample || !i_cfg.out_stereo) begin
            w_fmt.out_b = '0;
        end
        if (!i_side.sample) begin
            w_fmt.out_a = '0;
        end
    end

    // Hold the result item until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_out_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_out <= w_fmt;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

// ===== rtl/core/audio_format_converter.sv =====
// Top level: register port, channel mixing, result sequencer, lanes and merge.
//
// Audio format converter with linear-interpolation resampling. Each input item
// is one frame; it is mixed to the output channel count, converted to the
// output depth in two channel lanes, and resampled against the previous frame
// by a phase that advances by rate_step, raised to at least 1/MAX_UPSAMPLE of a
// frame (FRAC_BITS fraction bits), per result. The sequencer takes one frame at
// a time and emits one result per cycle while the output is not stalled: an
// item is taken in the idle state, then each pass issues its results and
// closes (the interpolation pass, and the hold pass on a last frame; a first
// frame that is not last has none), at most 16 results per frame. Issued
// results pass through the lane product register, then the output register. A
// stalled output stalls the sequencer; configuration may be written only while
// the block is idle.
module audio_format_converter #(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_UPSAMPLE = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [afc_pkg::ADDR_W-1:0]  paddr,
    input  logic [afc_pkg::DATA_W-1:0]  pwdata,
    output logic [afc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    afc_stream_if.sink                  i_in,
    afc_stream_if.source                o_out
);
    localparam int PW = ((FRAC_BITS + 1 > afc_pkg::STEP_W) ? FRAC_BITS + 1
                                                            : afc_pkg::STEP_W) + 1;
    localparam int KW = $clog2(MAX_UPSAMPLE + 1);
    localparam int MIN_STEP_I = ((1 << FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;
    localparam logic [PW-1:0] ONE      = PW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] TWO_ONE  = PW'(1) << (FRAC_BITS + 1);
    localparam logic [PW-1:0] MIN_STEP = PW'(MIN_STEP_I);
    localparam logic [KW-1:0] K_MAX    = KW'(MAX_UPSAMPLE);
    localparam logic [afc_pkg::CNT_W-1:0] N_LIMIT = afc_pkg::CNT_W'(afc_pkg::RESULT_LIMIT);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_INTERP = 2'd1;
    localparam logic [1:0] S_TAIL   = 2'd2;

    // Configuration registers
    logic                              r_in_stereo;
    logic                              r_out_stereo;
    logic                              r_in_16bit;
    logic                              r_out_16bit;
    logic [afc_pkg::STEP_W-1:0]        r_rate_step;
    logic                              r_mute;
    logic [afc_pkg::REG_IDX_W-1:0]     w_idx;
    logic                              w_wr;
    afc_pkg::t_cfg                     w_cfg;

    // Sequencer state
    logic [1:0]                        r_state, n_state;
    logic [PW-1:0]                     r_phase, n_phase;
    logic [KW-1:0]                     r_k, n_k;
    logic [afc_pkg::CNT_W-1:0]         r_n, n_n;
    logic                              r_have_prev, n_have_prev;
    logic                              r_last, n_last;
    afc_pkg::t_side                    r_s1;

    logic                              w_acc;
    logic                              w_en;
    logic                              w_cont;
    logic                              w_stop1;
    logic                              w_tail_empty;
    logic [PW-1:0]                     w_step;
    logic [PW-1:0]                     w_p1;
    logic [KW-1:0]                     w_k1;
    logic [afc_pkg::CNT_W-1:0]         w_n1;
    logic                              w_issue;
    logic                              w_iss_sample;
    logic                              w_iss_eob;
    afc_pkg::t_lane_ctrl               w_ctrl;

    // Channel mixing
    logic signed [15:0]                w_a16;
    logic signed [15:0]                w_b16;
    logic signed [16:0]                w_sum;
    logic signed [16:0]                w_half;
    logic signed [16:0]                w_avg;
    logic signed [15:0]                w_mix_a;
    logic signed [15:0]                w_mix_b;
    logic [15:0]                       w_left;
    logic [15:0]                       w_right;

    // Register port
    assign pready = 1'b1;
    assign w_idx  = paddr[afc_pkg::ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_stereo  <= 1'b0;
            r_out_stereo <= 1'b0;
            r_in_16bit   <= 1'b0;
            r_out_16bit  <= 1'b0;
            r_rate_step  <= afc_pkg::RATE_STEP_RESET;
            r_mute       <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                afc_pkg::REG_IN_STEREO:  r_in_stereo  <= pwdata[0];
                afc_pkg::REG_OUT_STEREO: r_out_stereo <= pwdata[0];
                afc_pkg::REG_IN_16BIT:   r_in_16bit   <= pwdata[0];
                afc_pkg::REG_OUT_16BIT:  r_out_16bit  <= pwdata[0];
                afc_pkg::REG_RATE_STEP:  r_rate_step  <= pwdata[afc_pkg::STEP_W-1:0];
                afc_pkg::REG_MUTE:       r_mute       <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_idx)
            afc_pkg::REG_IN_STEREO:  prdata = afc_pkg::DATA_W'(r_in_stereo);
            afc_pkg::REG_OUT_STEREO: prdata = afc_pkg::DATA_W'(r_out_stereo);
            afc_pkg::REG_IN_16BIT:   prdata = afc_pkg::DATA_W'(r_in_16bit);
            afc_pkg::REG_OUT_16BIT:  prdata = afc_pkg::DATA_W'(r_out_16bit);
            afc_pkg::REG_RATE_STEP:  prdata = afc_pkg::DATA_W'(r_rate_step);
            afc_pkg::REG_MUTE:       prdata = afc_pkg::DATA_W'(r_mute);
            default:                 prdata = '0;
        endcase
    end

    assign w_cfg = '{in_stereo:   r_in_stereo,
                     out_stereo:  r_out_stereo,
                     in_16bit:    r_in_16bit,
                     out_16bit:   r_out_16bit,
                     rate_step:   r_rate_step,
                     mute_enable: r_mute};

    // Decode source samples and mix channels (average truncates toward zero)
    assign w_a16 = r_in_16bit ? $signed(i_in.payload.in_a)
                              : $signed({8'h00, i_in.payload.in_a[7:0]});
    assign w_b16 = r_in_16bit ? $signed(i_in.payload.in_b)
                              : $signed({8'h00, i_in.payload.in_b[7:0]});
    assign w_sum  = 17'(w_a16) + 17'(w_b16);
    assign w_half = w_sum >>> 1;
    assign w_avg  = w_half + 17'(w_sum[16] & w_sum[0]);

    always_comb begin
        if (!r_in_stereo) begin
            w_mix_a = w_a16;
            w_mix_b = w_a16;
        end else if (!r_out_stereo) begin
            w_mix_a = w_avg[15:0];
            w_mix_b = w_avg[15:0];
        end else begin
            w_mix_a = w_a16;
            w_mix_b = w_b16;
        end
    end

    // Step clamp and one-result lookahead
    assign w_step = ({{(PW - afc_pkg::STEP_W){1'b0}}, r_rate_step} < MIN_STEP)
                  ? MIN_STEP : {{(PW - afc_pkg::STEP_W){1'b0}}, r_rate_step};
    assign w_p1   = r_phase + w_step;
    assign w_k1   = r_k + KW'(1);
    assign w_n1   = r_n + afc_pkg::CNT_W'(1);
    assign w_cont = (r_k < K_MAX) && (r_phase < ONE) && (r_n < N_LIMIT);
    assign w_stop1      = (w_k1 >= K_MAX) || (w_p1 >= ONE) || (w_n1 >= N_LIMIT);
    assign w_tail_empty = (w_n1 >= N_LIMIT) || (w_p1 >= TWO_ONE);

    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;

    // Result sequencer
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_k          = r_k;
        n_n          = r_n;
        n_have_prev  = r_have_prev;
        n_last       = r_last;
        w_issue      = 1'b0;
        w_iss_sample = 1'b0;
        w_iss_eob    = 1'b0;
        w_ctrl       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    w_ctrl.load      = 1'b1;
                    w_ctrl.load_prev = !r_have_prev;
                    n_have_prev      = 1'b1;
                    n_last           = i_in.payload.last_frame;
                    n_k              = '0;
                    n_n              = '0;
                    if (r_have_prev) begin
                        n_state = S_INTERP;
                    end else if (i_in.payload.last_frame) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_INTERP: begin
                if (w_cont) begin
                    if (w_en) begin
                        w_issue      = 1'b1;
                        w_iss_sample = 1'b1;
                        w_iss_eob    = r_last && w_stop1 && w_tail_empty;
                        n_phase      = w_p1;
                        n_k          = w_k1;
                        n_n          = w_n1;
                    end
                end else begin
                    // Wrap the phase onto the new frame and drop the old one
                    n_phase       = (r_phase >= ONE) ? (r_phase - ONE) : '0;
                    w_ctrl.commit = 1'b1;
                    n_k           = '0;
                    n_state       = r_last ? S_TAIL : S_IDLE;
                end
            end
            S_TAIL: begin
                if (w_cont) begin
                    if (w_en) begin
                        w_issue      = 1'b1;
                        w_iss_sample = 1'b1;
                        w_iss_eob    = w_stop1;
                        n_phase      = w_p1;
                        n_k          = w_k1;
                        n_n          = w_n1;
                    end
                end else if (r_n != '0 || w_en) begin
                    // Send a bare end marker if nothing came out, then restart
                    w_issue     = (r_n == '0);
                    w_iss_eob   = (r_n == '0);
                    n_phase     = '0;
                    n_have_prev = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_k         <= '0;
            r_n         <= '0;
            r_have_prev <= 1'b0;
            r_last      <= 1'b0;
            r_s1        <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_k         <= n_k;
            r_n         <= n_n;
            r_have_prev <= n_have_prev;
            r_last      <= n_last;
            if (w_en) begin
                r_s1 <= '{valid: w_issue, sample: w_iss_sample, eob: w_iss_eob};
            end
        end
    end

    // Channel lanes
    afc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_left (
        .i_clk    (i_clk),
        .i_cfg    (w_cfg),
        .i_ctrl   (w_ctrl),
        .i_en     (w_en),
        .i_sample (w_mix_a),
        .i_frac   (r_phase[FRAC_BITS-1:0]),
        .o_value  (w_left)
    );

    afc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_right (
        .i_clk    (i_clk),
        .i_cfg    (w_cfg),
        .i_ctrl   (w_ctrl),
        .i_en     (w_en),
        .i_sample (w_mix_b),
        .i_frac   (r_phase[FRAC_BITS-1:0]),
        .o_value  (w_right)
    );

    // Merge lanes into the output item
    afc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_side  (r_s1),
        .i_left  (w_left),
        .i_right (w_right),
        .o_en    (w_en),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    a_result_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= N_LIMIT)
        else $error("result count exceeds limit");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_iss_sample) |-> (r_phase < ONE) && (r_k < K_MAX))
        else $error("sample issued outside the interpolation window");

    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && !w_iss_sample) |-> w_iss_eob && (r_n == '0) && (r_state == S_TAIL))
        else $error("bare marker issued after samples");

    a_eob_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_iss_eob) |-> r_last)
        else $error("end of buffer on a frame that is not last");
`endif

endmodule

// ===== tb/sv/tb_audio_format_converter.sv =====
// Self-checking testbench for the audio format converter: predicted results checked per item.
module tb_audio_format_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import afc_pkg::*;

    localparam int FRAC_BITS     = 16;
    localparam int MAX_UPSAMPLE  = 8;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 17;

    // Predict the results of each frame and compare them as they come out.
    class resample_scoreboard #(int FRAC = 16, int UPS = 8);
        localparam int unsigned UNIT     = 32'd1 << FRAC;
        localparam int unsigned MIN_STEP = (UNIT + UPS - 1) / UPS;

        t_cfg        cfg;
        int          prev_l;
        int          prev_r;
        int unsigned phase_acc;
        bit          have_prev;
        t_out_item   due_results[$];
        int          n_errors;

        function new();
            cfg           = '0;
            cfg.rate_step = RATE_STEP_RESET;
            n_errors      = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            prev_l    = 0;
            prev_r    = 0;
            phase_acc = 0;
            have_prev = 1'b0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function int to_out_depth(int s);
            if (cfg.in_16bit == cfg.out_16bit) return s;
            if (cfg.out_16bit) return s * 256 - 32768;
            return (s + 32768) / 256;
        endfunction

        // Interpolate between two samples, truncating toward zero
        function int lerp(int p, int c, int unsigned frac);
            longint num;
            num = longint'(p) * longint'(UNIT) + longint'(c - p) * longint'(frac);
            return int'(num / longint'(UNIT));
        endfunction

        function void push_sample(int l, int r, bit has_sample, bit eob);
            t_out_item item;
            if (has_sample && cfg.mute_enable) begin
                l = cfg.out_16bit ? int'(SILENCE_16) : int'(SILENCE_8);
                r = l;
            end
            if (!has_sample || !cfg.out_stereo) r = 0;
            if (!has_sample) l = 0;
            item.out_a         = 16'(l);
            item.out_b         = 16'(r);
            item.sample_valid  = has_sample;
            item.end_of_buffer = eob;
            due_results.push_back(item);
        endfunction

        // Note an accepted frame: mix, convert depth, resample against the held frame
        function void convert_frame(t_in_item it);
            int          a;
            int          b;
            int          l;
            int          r;
            int          n;
            int unsigned step;
            t_out_item   tail;
            step = cfg.rate_step;
            if (step < MIN_STEP) step = MIN_STEP;
            if (cfg.in_16bit) begin
                a = int'($signed(it.in_a));
                b = int'($signed(it.in_b));
            end else begin
                a = int'(it.in_a[7:0]);
                b = int'(it.in_b[7:0]);
            end
            if (!cfg.in_stereo) begin
                b = a;
            end else if (!cfg.out_stereo) begin
                a = (a + b) / 2;
                b = a;
            end
            l = to_out_depth(a);
            r = to_out_depth(b);
            n = 0;

            if (have_prev) begin
                for (int k = 0; k < UPS && phase_acc < UNIT && n < RESULT_LIMIT; k++) begin
                    push_sample(lerp(prev_l, l, phase_acc), lerp(prev_r, r, phase_acc),
                                1'b1, 1'b0);
                    n++;
                    phase_acc += step;
                end
                phase_acc = (phase_acc >= UNIT) ? phase_acc - UNIT : 0;
            end
            prev_l    = l;
            prev_r    = r;
            have_prev = 1'b1;

            // Buffer end: hold the last frame up to one frame past it, then flag the end
            if (it.last_frame) begin
                for (int k = 0; k < UPS && phase_acc < UNIT && n < RESULT_LIMIT; k++) begin
                    push_sample(l, r, 1'b1, 1'b0);
                    n++;
                    phase_acc += step;
                end
                if (n > 0) begin
                    tail = due_results.pop_back();
                    tail.end_of_buffer = 1'b1;
                    due_results.push_back(tail);
                end else begin
                    push_sample(0, 0, 1'b0, 1'b1);
                end
                clear_stream();
            end
        endfunction

        task report(string msg);
            if (n_errors < 100) $display("error: %s", msg);
            n_errors++;
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result a=%h b=%h valid=%b end=%b",
                                 got.out_a, got.out_b, got.sample_valid, got.end_of_buffer));
                return;
            end
            want = due_results.pop_front();
            if (got.out_a !== want.out_a)
                report($sformatf("out_a %h, expected %h", got.out_a, want.out_a));
            if (got.out_b !== want.out_b)
                report($sformatf("out_b %h, expected %h", got.out_b, want.out_b));
            if (got.sample_valid !== want.sample_valid)
                report($sformatf("sample_valid %b, expected %b",
                                 got.sample_valid, want.sample_valid));
            if (got.end_of_buffer !== want.end_of_buffer)
                report($sformatf("end_of_buffer %b, expected %b",
                                 got.end_of_buffer, want.end_of_buffer));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    afc_stream_if #(.T(t_in_item))  in_if ();
    afc_stream_if #(.T(t_out_item)) out_if ();

    resample_scoreboard #(FRAC_BITS, MAX_UPSAMPLE) sb;

    int cycle_count = 0;
    int burst_left;
    bit steady;

    audio_format_converter #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watch both channels, pace the receiver, bound the run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && in_if.valid && in_if.ready) sb.convert_frame(in_if.payload);
        if (i_rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.payload);
        case ((cycle_count / 97) % 4)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= 1'($urandom_range(0, 1));
            2:       out_if.ready <= (cycle_count % 3) != 0;
            default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic t_cfg pack_cfg(bit in_st, bit out_st, bit in16, bit out16,
                                      int unsigned step, bit mute);
        t_cfg c;
        c.in_stereo   = in_st;
        c.out_stereo  = out_st;
        c.in_16bit    = in16;
        c.out_16bit   = out16;
        c.rate_step   = STEP_W'(step);
        c.mute_enable = mute;
        return c;
    endfunction

    function automatic t_in_item frame(logic [15:0] a, logic [15:0] b, logic last);
        t_in_item it;
        it.in_a       = a;
        it.in_b       = b;
        it.last_frame = last;
        return it;
    endfunction

    // Lean toward the sample extremes now and then
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(logic [REG_IDX_W-1:0] idx, output logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write every register with junk above its width, then read each one back
    task automatic apply_config(t_cfg c);
        logic [REG_IDX_W-1:0] regs [6];
        logic [DATA_W-1:0]    value [6];
        int                   width [6];
        logic [DATA_W-1:0]    junk;
        logic [DATA_W-1:0]    got;
        regs  = '{REG_IN_STEREO, REG_OUT_STEREO, REG_IN_16BIT, REG_OUT_16BIT,
                  REG_RATE_STEP, REG_MUTE};
        value = '{32'(c.in_stereo), 32'(c.out_stereo), 32'(c.in_16bit), 32'(c.out_16bit),
                  32'(c.rate_step), 32'(c.mute_enable)};
        width = '{1, 1, 1, 1, STEP_W, 1};
        for (int i = 0; i < 6; i++) begin
            junk = $urandom();
            apb_write(regs[i], (junk & ~((32'd1 << width[i]) - 32'd1)) | value[i]);
        end
        for (int i = 0; i < 6; i++) begin
            apb_read(regs[i], got);
            if (got !== value[i])
                sb.report($sformatf("register %0d reads %h, written %h", regs[i], got,
                                    value[i]));
        end
        sb.cfg = c;
    endtask

    // Present one frame and hold it until the block takes it
    task automatic send_frame(t_in_item it);
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Send in bursts of random length with random gaps, unless the phase runs steady
    task automatic feed(t_in_item it);
        send_frame(it);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 7);
            if (!steady) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid, wait for every expected result, then let the block settle
    task automatic wait_idle(int extra);
        int guard;
        guard = 0;
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (extra) @(posedge i_clk);
    endtask

    initial begin
        t_cfg        c;
        int unsigned step;
        int          sent;
        int          blen;
        sb = new();
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_if.valid   <= 1'b0;
        in_if.payload <= '0;
        burst_left = 0;
        steady     = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Stereo 16-bit to mono 16-bit: averages of extremes and negative sums
        apply_config(pack_cfg(1, 0, 1, 1, 65536, 0));
        feed(frame(16'h7FFF, 16'h7FFF, 1'b0));
        feed(frame(16'h8000, 16'h8000, 1'b0));
        feed(frame(16'h7FFF, 16'h8000, 1'b0));
        feed(frame(16'hFFFF, 16'hFFFE, 1'b0));
        feed(frame(16'hFFFF, 16'h0001, 1'b1));
        wait_idle(SETTLE_CYCLES);

        // Mono 8-bit to stereo 16-bit; zero step is raised, so the limit of results is hit
        apply_config(pack_cfg(0, 1, 0, 1, 0, 0));
        feed(frame(16'h00FF, 16'h1234, 1'b0));
        feed(frame(16'hFF00, 16'hFFFF, 1'b0));
        feed(frame(16'h0080, 16'h0000, 1'b1));
        wait_idle(SETTLE_CYCLES);

        // Stereo 16-bit to 8-bit at a step of 16 frames: skipped frames, bare end marker
        apply_config(pack_cfg(1, 1, 1, 0, 1048576, 0));
        feed(frame(16'h8000, 16'h7FFF, 1'b0));
        feed(frame(16'h0000, 16'hFFFF, 1'b0));
        feed(frame(16'h1234, 16'hABCD, 1'b1));
        wait_idle(SETTLE_CYCLES);

        // Muted 8-bit stereo to mono, then a buffer of one frame
        apply_config(pack_cfg(1, 0, 0, 0, 32768, 1));
        feed(frame(16'h00FF, 16'h0001, 1'b0));
        feed(frame(16'hFF00, 16'h00FF, 1'b1));
        feed(frame(16'h0055, 16'hAA00, 1'b1));
        wait_idle(SETTLE_CYCLES);

        // Random buffers under a new setting per phase
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       step = 8192;
                1:       step = 1048576;
                2:       step = 0;
                3:       step = $urandom_range(1, 8191);
                4:       step = 65536;
                5:       step = $urandom_range(8192, 1048576);
                default: step = $urandom_range(8192, 131072);
            endcase
            c = pack_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), step,
                         $urandom_range(0, 4) == 0);
            apply_config(c);
            steady = ($urandom_range(0, 3) == 0);
            sent   = 0;
            while (sent < PHASE_ITEMS) begin
                blen = $urandom_range(1, 10);
                if (blen > PHASE_ITEMS - sent) blen = PHASE_ITEMS - sent;
                for (int k = 0; k < blen; k++) begin
                    // Hold off mid-buffer until the block has delivered everything
                    if (p == 1 && sent == PHASE_ITEMS / 2) wait_idle(0);
                    feed(frame(rand_sample(), rand_sample(), k == blen - 1));
                    sent++;
                end
            end
            wait_idle(SETTLE_CYCLES);
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        if (sb.n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
